// ===== rtl/core/knn_pkg.sv =====
`default_nettype none

package knn_pkg;

  localparam int NEIGHBORS   = 4;
  localparam int DIMENSIONS  = 4;
  localparam int COORDS      = 4;
  localparam int ID_W        = 20;
  localparam int COORD_W     = 16;
  localparam int SQ_W        = 2 * COORD_W;
  localparam int DIST_W      = 34;
  localparam int SLOT_W      = (NEIGHBORS > 1) ? $clog2(NEIGHBORS) : 1;
  localparam int CNT_W       = $clog2(NEIGHBORS + 1);
  // power of two, pointers wrap on their own
  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int CFG_IDX_W   = 2;

  typedef logic [COORDS-1:0][COORD_W-1:0] coord_vec_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_QUERY_X0,
    CFG_QUERY_X1,
    CFG_QUERY_X2,
    CFG_QUERY_X3
  } cfg_idx_t;

  typedef struct packed {
    logic [ID_W-1:0]   id;
    logic [DIST_W-1:0] sq_dist;
    logic              eoq;
  } cand_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

endpackage

`default_nettype wire

// ===== rtl/core/knn_ram.sv =====
`default_nettype none

module knn_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4,
  localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

// ===== rtl/core/knn_fifo.sv =====
`default_nettype none

module knn_fifo (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            push,
  input  knn_pkg::cand_t  din,
  input  logic            pop,
  output knn_pkg::cand_t  dout,
  output knn_pkg::q_stat_t stat
);

  import knn_pkg::*;

  cand_t             mem_r [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [QPTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [QPTR_W:0]   count_r, count_nxt;
  logic              do_push, do_pop;

  assign stat.full  = (count_r == (QPTR_W+1)'(QUEUE_DEPTH));
  assign stat.empty = (count_r == '0);
  assign do_push    = push && !stat.full;
  assign do_pop     = pop && !stat.empty;
  assign dout       = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = do_push ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = do_pop ? rd_ptr_r + 1'b1 : rd_ptr_r;
    count_nxt  = count_r + (QPTR_W+1)'(do_push) - (QPTR_W+1)'(do_pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= din;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/core/knn_front.sv =====
`default_nettype none

module knn_front (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [knn_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [knn_pkg::COORD_W-1:0]   cfg_data,
  input  logic                          in_push,
  output logic                          in_full,
  input  logic [knn_pkg::ID_W-1:0]      in_point_id,
  input  knn_pkg::coord_vec_t           in_coord,
  input  logic                          in_end_of_query,
  output logic                          q_push,
  output knn_pkg::cand_t                q_din,
  input  knn_pkg::q_stat_t              q_stat
);

  import knn_pkg::*;

  coord_vec_t                         query_r;
  logic                               s1_v_r, s2_v_r, s3_v_r;
  logic [ID_W-1:0]                    s1_id_r, s2_id_r;
  logic                               s1_eoq_r, s2_eoq_r;
  logic [COORDS-1:0][COORD_W-1:0]     mag_r, mag_nxt;
  logic [COORDS-1:0][SQ_W-1:0]        sq_r, sq_nxt;
  logic [DIST_W-1:0]                  sum_nxt;
  cand_t                              s3_r;
  logic                               adv;

  assign cfg_ready = 1'b1;
  // whole pipe moves together, holds while the last stage waits on the queue
  assign adv       = !s3_v_r || !q_stat.full;
  assign in_full   = !adv;
  assign q_push    = s3_v_r && !q_stat.full;
  assign q_din     = s3_r;

  always_comb begin
    logic signed [COORD_W:0] diff;
    logic signed [COORD_W:0] neg;
    for (int d = 0; d < COORDS; d++) begin
      diff = $signed({in_coord[d][COORD_W-1], in_coord[d]})
           - $signed({query_r[d][COORD_W-1], query_r[d]});
      neg  = -diff;
      if (d < DIMENSIONS) begin
        mag_nxt[d] = diff[COORD_W] ? neg[COORD_W-1:0] : diff[COORD_W-1:0];
      end else begin
        mag_nxt[d] = '0;
      end
    end
  end

  always_comb begin
    for (int d = 0; d < COORDS; d++) begin
      sq_nxt[d] = SQ_W'(mag_r[d]) * SQ_W'(mag_r[d]);
    end
  end

  always_comb begin
    sum_nxt = '0;
    for (int d = 0; d < COORDS; d++) begin
      sum_nxt = sum_nxt + DIST_W'(sq_r[d]);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      query_r <= '0;
    end else if (cfg_valid) begin
      unique case (cfg_idx_t'(cfg_index))
        CFG_QUERY_X0: query_r[0] <= cfg_data;
        CFG_QUERY_X1: query_r[1] <= cfg_data;
        CFG_QUERY_X2: query_r[2] <= cfg_data;
        CFG_QUERY_X3: query_r[3] <= cfg_data;
        default:      query_r    <= query_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
      s2_v_r <= 1'b0;
      s3_v_r <= 1'b0;
    end else if (adv) begin
      s1_v_r <= in_push;
      s2_v_r <= s1_v_r;
      s3_v_r <= s2_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s1_id_r      <= in_point_id;
      s1_eoq_r     <= in_end_of_query;
      mag_r        <= mag_nxt;
      s2_id_r      <= s1_id_r;
      s2_eoq_r     <= s1_eoq_r;
      sq_r         <= sq_nxt;
      s3_r.id      <= s2_id_r;
      s3_r.eoq     <= s2_eoq_r;
      s3_r.sq_dist <= sum_nxt;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/core/knn_back.sv =====
`default_nettype none

module knn_back (
  input  logic                       clk,
  input  logic                       rst_n,
  input  knn_pkg::cand_t             q_dout,
  input  knn_pkg::q_stat_t           q_stat,
  output logic                       q_pop,
  output logic                       out_empty,
  input  logic                       out_pop,
  output logic [knn_pkg::ID_W-1:0]   out_neighbor_id,
  output logic [knn_pkg::DIST_W-1:0] out_neighbor_dist,
  output logic                       out_slot_valid,
  output logic                       out_last_slot
);

  import knn_pkg::*;

  typedef struct packed {
    logic [ID_W-1:0]   id;
    logic [DIST_W-1:0] sq_dist;
  } slot_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_EMIT_RD,
    ST_EMIT_WR
  } state_t;

  state_t              state_r, state_nxt;
  logic [CNT_W-1:0]    fill_r, fill_nxt;
  logic [DIST_W-1:0]   worst_r, worst_nxt;
  logic [SLOT_W-1:0]   wslot_r, wslot_nxt;
  logic [CNT_W-1:0]    scan_r, scan_nxt;
  logic [SLOT_W-1:0]   emit_r, emit_nxt;
  logic                out_v_r, out_v_nxt;
  logic [ID_W-1:0]     oid_r, oid_nxt;
  logic [DIST_W-1:0]   odist_r, odist_nxt;
  logic                oval_r, oval_nxt;
  logic                olast_r, olast_nxt;

  logic                ram_we, ram_re;
  logic [SLOT_W-1:0]   ram_waddr, ram_raddr;
  slot_t               ram_wdata, ram_rdata;

  knn_ram #(
    .WIDTH ($bits(slot_t)),
    .DEPTH (NEIGHBORS)
  ) u_slots (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign out_empty         = !out_v_r;
  assign out_neighbor_id   = oid_r;
  assign out_neighbor_dist = odist_r;
  assign out_slot_valid    = oval_r;
  assign out_last_slot     = olast_r;

  always_comb begin
    logic need_scan;
    logic valid;
    logic last;
    state_nxt         = state_r;
    fill_nxt          = fill_r;
    worst_nxt         = worst_r;
    wslot_nxt         = wslot_r;
    scan_nxt          = scan_r;
    emit_nxt          = emit_r;
    out_v_nxt         = out_v_r && !out_pop;
    oid_nxt           = oid_r;
    odist_nxt         = odist_r;
    oval_nxt          = oval_r;
    olast_nxt         = olast_r;
    q_pop             = 1'b0;
    ram_we            = 1'b0;
    ram_waddr         = fill_r[SLOT_W-1:0];
    ram_wdata.id      = q_dout.id;
    ram_wdata.sq_dist = q_dout.sq_dist;
    ram_re            = 1'b0;
    ram_raddr         = emit_r;
    need_scan         = 1'b0;
    valid             = (CNT_W'(emit_r) < fill_r);
    last              = (emit_r == SLOT_W'(NEIGHBORS - 1));

    unique case (state_r)
      ST_IDLE: begin
        if (!q_stat.empty) begin
          q_pop = 1'b1;
          if (fill_r < CNT_W'(NEIGHBORS)) begin
            ram_we    = 1'b1;
            fill_nxt  = fill_r + 1'b1;
            need_scan = (fill_r == CNT_W'(NEIGHBORS - 1)) && !q_dout.eoq;
          end else if (q_dout.sq_dist < worst_r) begin
            ram_we    = 1'b1;
            ram_waddr = wslot_r;
            need_scan = !q_dout.eoq;
          end
          // the readout clears the worst tracking, so no scan before it
          if (q_dout.eoq) begin
            state_nxt = ST_EMIT_RD;
            emit_nxt  = '0;
          end else if (need_scan) begin
            state_nxt = ST_SCAN;
            scan_nxt  = '0;
          end
        end
      end
      ST_SCAN: begin
        // read slot scan_r, compare the slot read in the previous cycle
        ram_re    = (scan_r < CNT_W'(NEIGHBORS));
        ram_raddr = scan_r[SLOT_W-1:0];
        scan_nxt  = scan_r + 1'b1;
        if (scan_r != '0) begin
          if (scan_r == CNT_W'(1) || ram_rdata.sq_dist > worst_r) begin
            worst_nxt = ram_rdata.sq_dist;
            wslot_nxt = SLOT_W'(scan_r - 1'b1);
          end
        end
        if (scan_r == CNT_W'(NEIGHBORS)) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_EMIT_RD: begin
        ram_re    = 1'b1;
        state_nxt = ST_EMIT_WR;
      end
      ST_EMIT_WR: begin
        if (!out_v_r || out_pop) begin
          out_v_nxt = 1'b1;
          oval_nxt  = valid;
          oid_nxt   = valid ? ram_rdata.id : '0;
          odist_nxt = valid ? ram_rdata.sq_dist : '0;
          olast_nxt = last;
          if (last) begin
            fill_nxt  = '0;
            worst_nxt = '0;
            wslot_nxt = '0;
            state_nxt = ST_IDLE;
          end else begin
            emit_nxt  = emit_r + 1'b1;
            state_nxt = ST_EMIT_RD;
          end
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      fill_r  <= '0;
      worst_r <= '0;
      wslot_r <= '0;
      scan_r  <= '0;
      emit_r  <= '0;
      out_v_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      fill_r  <= fill_nxt;
      worst_r <= worst_nxt;
      wslot_r <= wslot_nxt;
      scan_r  <= scan_nxt;
      emit_r  <= emit_nxt;
      out_v_r <= out_v_nxt;
    end
    oid_r   <= oid_nxt;
    odist_r <= odist_nxt;
    oval_r  <= oval_nxt;
    olast_r <= olast_nxt;
  end

endmodule

`default_nettype wire

// ===== rtl/core/knn_top_k_tracker_core.sv =====
// channel   direction  handshake            payload
// in_       input      in_push / in_full    point_id, coord_0..3, end_of_query
// out_      output     out_empty / out_pop  neighbor_id, neighbor_dist, slot_valid, last_slot
// cfg_      input      cfg_valid/cfg_ready  cfg_index, cfg_data (query_x0..3)
//
// the front computes the squared distance in a three-stage pipe, one candidate per cycle
// unless a full queue holds it, and hands it to a four-entry queue; the back takes one
// candidate per cycle from it while idle. a candidate that fills the last slot or replaces
// one, and does not end the query, is followed in the back by a scan of the slot memory,
// one slot per cycle, that finds the new worst slot.
// an end-of-query readout passes each slot through a memory read, then the output register.
// reset is synchronous, active low; the slot memory needs no clearing pass.
// in_full rises only when the queue is full and the pipe's last stage holds a candidate.
`default_nettype none

module knn_top_k_tracker_core (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [knn_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [knn_pkg::COORD_W-1:0]   cfg_data,
  input  logic                          in_push,
  output logic                          in_full,
  input  logic [knn_pkg::ID_W-1:0]      in_point_id,
  input  logic signed [knn_pkg::COORD_W-1:0] in_coord_0,
  input  logic signed [knn_pkg::COORD_W-1:0] in_coord_1,
  input  logic signed [knn_pkg::COORD_W-1:0] in_coord_2,
  input  logic signed [knn_pkg::COORD_W-1:0] in_coord_3,
  input  logic                          in_end_of_query,
  output logic                          out_empty,
  input  logic                          out_pop,
  output logic [knn_pkg::ID_W-1:0]      out_neighbor_id,
  output logic [knn_pkg::DIST_W-1:0]    out_neighbor_dist,
  output logic                          out_slot_valid,
  output logic                          out_last_slot
);

  import knn_pkg::*;

  coord_vec_t coord_vec;
  cand_t      q_din, q_dout;
  q_stat_t    q_stat;
  logic       q_push, q_pop;

  assign coord_vec = {in_coord_3, in_coord_2, in_coord_1, in_coord_0};

  knn_front u_front (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg_valid       (cfg_valid),
    .cfg_ready       (cfg_ready),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data),
    .in_push         (in_push),
    .in_full         (in_full),
    .in_point_id     (in_point_id),
    .in_coord        (coord_vec),
    .in_end_of_query (in_end_of_query),
    .q_push          (q_push),
    .q_din           (q_din),
    .q_stat          (q_stat)
  );

  knn_fifo u_queue (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (q_push),
    .din   (q_din),
    .pop   (q_pop),
    .dout  (q_dout),
    .stat  (q_stat)
  );

  knn_back u_back (
    .clk               (clk),
    .rst_n             (rst_n),
    .q_dout            (q_dout),
    .q_stat            (q_stat),
    .q_pop             (q_pop),
    .out_empty         (out_empty),
    .out_pop           (out_pop),
    .out_neighbor_id   (out_neighbor_id),
    .out_neighbor_dist (out_neighbor_dist),
    .out_slot_valid    (out_slot_valid),
    .out_last_slot     (out_last_slot)
  );

`ifndef SYNTHESIS
  a_full_only_on_queue: assert property (@(posedge clk) disable iff (!rst_n)
    in_full |-> q_stat.full)
    else $error("input stalled while the queue has room");

  a_queue_stat: assert property (@(posedge clk) disable iff (!rst_n)
    !(q_stat.full && q_stat.empty))
    else $error("queue reports full and empty at once");

  a_empty_slot_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (!out_empty && !out_slot_valid) |-> (out_neighbor_id == '0 && out_neighbor_dist == '0))
    else $error("empty slot carries data");

  a_push_when_room: assert property (@(posedge clk) disable iff (!rst_n)
    q_push |-> !q_stat.full)
    else $error("push into a full queue");
`endif

endmodule

`default_nettype wire
